// ===== design/sha_pkg.sv =====
// Package for the SHA-256 byte stream hasher: round constants, initial hash values,
// controller states and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none
package sha_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_FOLD,
        S_PAD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] load_data;
        logic       pad_write;
        logic [5:0] pad_addr;
        logic [7:0] pad_data;
        logic       round_start;
        logic       round_step;
        logic [5:0] round_idx;
        logic       fold;
        logic       clear;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic [63:0] total_bits;
    } t_status;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== design/sha_datapath.sv =====
// Datapath of the SHA-256 hasher: block buffer as sixteen words that also serve
// as the message schedule window, working variables, chaining words, fill and bit count.
// Depends on sha_pkg.
`default_nettype none
module sha_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  sha_pkg::t_cmd    i_cmd,
    output sha_pkg::t_status o_status,
    input  wire  [2:0]       i_out_idx,
    output logic [31:0]      o_digest_word
);
    import sha_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] s0, s1, n_w, big0, big1, ch, maj, t1, t2, w_cur;
    logic [3:0]  wr_word;
    logic [1:0]  wr_lane;
    logic [7:0]  wr_data;
    logic        wr_en;
    logic [5:0]  wr_addr;

    always_comb begin
        w_cur = r_w[0];
        s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
        n_w = r_w[0] + s0 + r_w[9] + s1;
        big1 = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + big1 + ch + round_k(i_cmd.round_idx) + w_cur;
        big0 = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = big0 + maj;
        wr_en = i_cmd.load_byte || i_cmd.pad_write;
        wr_addr = i_cmd.load_byte ? r_fill : i_cmd.pad_addr;
        wr_data = i_cmd.load_byte ? i_cmd.load_data : i_cmd.pad_data;
        wr_word = wr_addr[5:2];
        wr_lane = wr_addr[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round_step) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= n_w;
        end else if (wr_en) begin
            case (wr_lane)
                2'd0: r_w[wr_word][31:24] <= wr_data;
                2'd1: r_w[wr_word][23:16] <= wr_data;
                2'd2: r_w[wr_word][15:8]  <= wr_data;
                default: r_w[wr_word][7:0] <= wr_data;
            endcase
        end
        if (i_cmd.round_start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round_step) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= init_hash(3'(i));
            end
            r_fill <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            if (i_cmd.load_byte) begin
                r_fill <= r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    r_bits <= r_bits + 64'd512;
                end
            end
        end
    end

    assign o_status.fill = r_fill;
    assign o_status.total_bits = r_bits + {55'd0, r_fill, 3'd0};
    assign o_digest_word = r_h[i_out_idx];

endmodule
`default_nettype wire

// ===== design/sha_ctrl.sv =====
// Controller of the SHA-256 hasher: sequences byte loads, padding, the 64 rounds,
// the chaining fold and the eight digest words.
// Depends on sha_pkg.
`default_nettype none
module sha_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire              i_kind,
    input  wire  [7:0]       i_data_byte,
    output logic             o_stall,
    input  sha_pkg::t_status i_status,
    output sha_pkg::t_cmd    o_cmd,
    output logic             o_valid,
    input  wire              i_stall,
    output logic [2:0]       o_word_index
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [5:0]  r_pad_pos, n_pad_pos;
    logic        r_final, n_final;
    logic [63:0] r_len, n_len;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_pending;
    logic        len_block;

    assign len_block = r_final || (r_len[8:6] != 3'b111);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_pad_pos <= '0;
            r_final <= 1'b0;
            r_oidx <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pad_pos <= n_pad_pos;
            r_final <= n_final;
            r_oidx <= n_oidx;
        end
        r_len <= n_len;
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_pad_pos = r_pad_pos;
        n_final = r_final;
        n_len = r_len;
        n_oidx = r_oidx;
        o_cmd = '0;
        o_cmd.round_idx = r_cnt;
        o_cmd.load_data = i_data_byte;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (!i_kind) begin
                        o_cmd.load_byte = 1'b1;
                        if (i_status.fill == 6'd63) begin
                            o_cmd.round_start = 1'b1;
                            n_cnt = '0;
                            n_final = 1'b0;
                            n_state = S_COMP;
                        end
                    end else begin
                        n_len = i_status.total_bits;
                        o_cmd.pad_write = 1'b1;
                        o_cmd.pad_addr = i_status.fill;
                        o_cmd.pad_data = PAD_BYTE;
                        n_pad_pos = i_status.fill + 6'd1;
                        n_final = 1'b0;
                        if (i_status.fill == 6'd63) begin
                            o_cmd.round_start = 1'b1;
                            n_cnt = '0;
                            n_state = S_COMP;
                        end else begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad_write = 1'b1;
                o_cmd.pad_addr = r_pad_pos;
                if (len_block && r_pad_pos >= 6'd56) begin
                    o_cmd.pad_data = r_len[8*(63 - r_pad_pos) +: 8];
                end else begin
                    o_cmd.pad_data = 8'h00;
                end
                n_pad_pos = r_pad_pos + 6'd1;
                if (r_pad_pos == 6'd63) begin
                    o_cmd.round_start = 1'b1;
                    n_cnt = '0;
                    n_final = len_block;
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                o_cmd.round_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_oidx = '0;
                if (r_final) begin
                    n_state = S_EMIT;
                end else if (i_status.fill == 6'd0 && r_pad_pos == 6'd0 && !r_pending) begin
                    n_state = S_IDLE;
                end else begin
                    n_pad_pos = '0;
                    n_final = 1'b1;
                    n_state = S_PAD;
                end
            end
            S_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A pending finish is tracked so that a block compressed after padding
    // leads on to the length block rather than back to idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (r_state == S_IDLE && i_valid && i_kind) begin
            r_pending <= 1'b1;
        end else if (r_state == S_EMIT) begin
            r_pending <= 1'b0;
        end
    end

    assign o_word_index = r_oidx;

endmodule
`default_nettype wire

// ===== design/sha256_byte_stream_hasher.sv =====
// SHA-256 over a byte stream: one byte is taken per cycle while the block fills;
// a full block then stalls the input through its 64 rounds, one per cycle, and the fold.
// A finish pads the block at one byte per cycle, runs one or two compressions and
// presents eight digest words, one per cycle unless stalled.
// Reset is synchronous, active low, and restores the initial hash values.
`default_nettype none
module sha256_byte_stream_hasher (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_kind,
    input  wire  [7:0]  i_data_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    t_cmd    cmd;
    t_status status;

    sha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_kind(i_kind),
        .i_data_byte(i_data_byte), .o_stall(o_stall), .i_status(status),
        .o_cmd(cmd), .o_valid(o_valid), .i_stall(i_stall), .o_word_index(o_word_index)
    );

    sha_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_out_idx(o_word_index), .o_digest_word(o_digest_word)
    );

    assign o_last_word = (o_word_index == 3'd7);

`ifndef NO_ASSERTIONS
    a_no_out_while_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken during digest output");
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=> (o_valid && o_word_index != 3'd0))
        else $error("digest index did not advance");
    a_ctrl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.round_step && cmd.load_byte)) else $error("load during rounds");
`endif

endmodule
`default_nettype wire

// ===== verif/sha256_byte_stream_hasher_tb.sv =====
// Testbench for the SHA-256 byte stream hasher: messages of random and chosen lengths are
// sent, the digest is computed here bit for bit and compared word by word with the output.
// Depends on sha_pkg and the sha256_byte_stream_hasher module.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher_tb;
    import sha_pkg::*;

    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned msg_fill;
    logic [63:0] msg_bit_count;
    t_digest_out expected_words [$];
    int          send_gap_pct;
    int          recv_stall_pct;
    bit          failed;

    sha256_byte_stream_hasher i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_data_byte(i_data_byte), .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++) begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            w[t] = w[t-16] + w[t-7]
                + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) hash_state[i] = init_hash(i[2:0]);
        msg_fill = 0;
        msg_bit_count = '0;
    endfunction

    function automatic void predict_word(input logic kind, input logic [7:0] data);
        logic [63:0] total;
        int unsigned f;
        t_digest_out item;
        if (kind == KIND_ABSORB) begin
            msg_block[msg_fill] = data;
            msg_fill++;
            if (msg_fill == 64) begin
                compress_block();
                msg_bit_count += 64'd512;
                msg_fill = 0;
            end
            return;
        end
        total = msg_bit_count + 64'(msg_fill) * 8;
        f = msg_fill;
        msg_block[f] = PAD_BYTE;
        f++;
        if (f > 56) begin
            while (f < 64) begin
                msg_block[f] = 8'h00;
                f++;
            end
            compress_block();
            f = 0;
        end
        while (f < 56) begin
            msg_block[f] = 8'h00;
            f++;
        end
        for (int i = 0; i < 8; i++) msg_block[63 - i] = total[8*i +: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            item.digest_word = hash_state[i];
            item.word_index = i[2:0];
            item.last_word = (i == 7);
            expected_words.push_back(item);
        end
        restart_message();
    endfunction

    task automatic send_word(input logic kind, input logic [7:0] data);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            i_kind <= 1'($urandom_range(1));
            i_data_byte <= 8'($urandom_range(255));
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_word(kind, data);
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_word(KIND_ABSORB, 8'($urandom_range(255)));
        end
        send_word(KIND_FINISH, 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_digest_out got, exp;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_digest_word, o_word_index, o_last_word};
            if (expected_words.size() == 0) begin
                $display("%t unexpected word: actual %h", $time, got);
                failed = 1'b1;
            end else begin
                exp = expected_words.pop_front();
                if (got.digest_word !== exp.digest_word) begin
                    $display("%t digest_word: expected %h actual %h", $time,
                             exp.digest_word, got.digest_word);
                    failed = 1'b1;
                end
                if (got.word_index !== exp.word_index) begin
                    $display("%t word_index: expected %0d actual %0d", $time,
                             exp.word_index, got.word_index);
                    failed = 1'b1;
                end
                if (got.last_word !== exp.last_word) begin
                    $display("%t last_word: expected %b actual %b", $time,
                             exp.last_word, got.last_word);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic test_directed();
        send_word(KIND_FINISH, 8'hff);
        send_word(KIND_ABSORB, 8'h00);
        send_word(KIND_ABSORB, 8'hff);
        send_word(KIND_ABSORB, 8'h80);
        send_word(KIND_FINISH, 8'h00);
        send_word(KIND_ABSORB, 8'h61);
        send_word(KIND_FINISH, 8'h00);
        send_word(KIND_FINISH, 8'h00);
        wait_drained();
    endtask

    task automatic test_pad_boundaries();
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);
        wait_drained();
    endtask

    task automatic test_random(input int unsigned count, input int gap, input int stall);
        int unsigned sent;
        int unsigned len;
        send_gap_pct = gap;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
            if (len >= count - sent) len = count - sent - 1;
            send_message(len);
            sent += len + 1;
        end
        wait_drained();
    endtask

    initial begin
        failed = 1'b0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        restart_message();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pad_boundaries();
        test_random(16, 0, 0);
        test_random(16, 71, 0);
        test_random(16, 0, 71);
        test_random(16, 27, 27);
        recv_stall_pct = 0;
        repeat (300) @(posedge i_clk);
        if (!failed && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
